// ===== rtl/crtcp_pkg.sv =====
// Shared constants and types for the cascaded real-time clock prescaler.
// Used by the step logic, the register block and the top level.
`default_nettype none

package crtcp_pkg;

   // Prescaler configuration.
   localparam int TICKS_PER_MILLI = 8;
   localparam int COUNT_WIDTH     = 16;

   localparam int TICK_W = (TICKS_PER_MILLI > 1) ? $clog2(TICKS_PER_MILLI) : 1;

   localparam int MILLI_W  = 7;
   localparam int TENTH_W  = 4;
   localparam int SECOND_W = 6;

   localparam logic [MILLI_W-1:0]  LAST_MILLI_IN_TENTH   = 7'd99;
   localparam logic [TENTH_W-1:0]  LAST_TENTH_IN_SECOND  = 4'd9;
   localparam logic [SECOND_W-1:0] LAST_SECOND_IN_MINUTE = 6'd59;
   localparam logic [TICK_W-1:0]   LAST_TICK_PHASE       = TICK_W'(TICKS_PER_MILLI - 1);

   localparam logic [7:0] DEBUG_ALL_ONES = 8'hFF;

   // Event codes carried in the action field.
   localparam logic ACTION_TICK     = 1'b0;
   localparam logic ACTION_OVERFLOW = 1'b1;

   // Register map: one register, word index taken from paddr[2].
   localparam int          CSR_ADDR_W               = 3;
   localparam logic        CSR_IDX_READING_TIMEOUT  = 1'b0;
   localparam logic [15:0] READING_TIMEOUT_RESET    = 16'd20;

   typedef struct packed {
      logic [TICK_W-1:0]      tick_phase;
      logic [COUNT_WIDTH-1:0] millis_total;
      logic [MILLI_W-1:0]     millis_in_tenth;
      logic [COUNT_WIDTH-1:0] tenths_total;
      logic [TENTH_W-1:0]     tenths_in_second;
      logic [COUNT_WIDTH-1:0] seconds_total;
      logic [SECOND_W-1:0]    seconds_in_minute;
      logic [COUNT_WIDTH-1:0] minutes_total;
      logic [15:0]            adc_wait;
      logic [7:0]             debounce_left;
      logic                   pump_bit;
      logic [7:0]             debug_value;
      logic [15:0]            overflow_count;
   } state_type;

   typedef struct packed {
      logic adc_read_due;
      logic send_log;
   } pulse_type;

endpackage

`default_nettype wire

// ===== rtl/crtcp_req_if.sv =====
// Input channel of the prescaler: one event word per handshake.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface crtcp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic       debounce_load_valid;
   logic [7:0] debounce_load_value;

   modport source (output valid, output action, output debounce_load_valid,
                   output debounce_load_value, input ready);
   modport sink   (input valid, input action, input debounce_load_valid,
                   input debounce_load_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/crtcp_rsp_if.sv =====
// Result channel of the prescaler: one status word per handshake.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface crtcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] millis_count;
   logic [15:0] tenths_count;
   logic [15:0] seconds_count;
   logic [15:0] minutes_count;
   logic [15:0] timer_extension;
   logic        adc_read_due;
   logic        send_log;
   logic        fuel_pump_led;
   logic [7:0]  debug_port;
   logic [7:0]  debounce_count;

   modport source (output valid, output millis_count, output tenths_count,
                   output seconds_count, output minutes_count, output timer_extension,
                   output adc_read_due, output send_log, output fuel_pump_led,
                   output debug_port, output debounce_count, input ready);
   modport sink   (input valid, input millis_count, input tenths_count,
                   input seconds_count, input minutes_count, input timer_extension,
                   input adc_read_due, input send_log, input fuel_pump_led,
                   input debug_port, input debounce_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/crtcp_step.sv =====
// Next-state logic of the prescaler chain for one event word.
// Depends on crtcp_pkg for the state layout and the chain limits.
`default_nettype none

module crtcp_step (
   input  crtcp_pkg::state_type state_cur,
   input  logic                 action,
   input  logic                 load_valid,
   input  logic [7:0]           load_value,
   input  logic [15:0]          reading_timeout,
   output crtcp_pkg::state_type state_nxt,
   output crtcp_pkg::pulse_type pulses
);
   import crtcp_pkg::*;

   logic        milli_edge;
   logic        tenth_edge;
   logic        second_edge;
   logic        minute_edge;
   logic [15:0] adc_inc;
   logic [7:0]  debounce_loaded;

   assign milli_edge  = (action == ACTION_TICK) && (state_cur.tick_phase == LAST_TICK_PHASE);
   assign tenth_edge  = milli_edge && (state_cur.millis_in_tenth == LAST_MILLI_IN_TENTH);
   assign second_edge = tenth_edge && (state_cur.tenths_in_second == LAST_TENTH_IN_SECOND);
   assign minute_edge = second_edge &&
                        (state_cur.seconds_in_minute == LAST_SECOND_IN_MINUTE);

   assign adc_inc         = state_cur.adc_wait + 16'd1;
   assign debounce_loaded = load_valid ? load_value : state_cur.debounce_left;

   always_comb begin
      state_nxt = state_cur;
      pulses    = '0;

      if (action == ACTION_OVERFLOW) begin
         state_nxt.overflow_count = state_cur.overflow_count + 16'd1;
      end else if (milli_edge) begin
         state_nxt.tick_phase = '0;
      end else begin
         state_nxt.tick_phase = state_cur.tick_phase + TICK_W'(1);
      end

      if (milli_edge) begin
         state_nxt.millis_total = state_cur.millis_total + COUNT_WIDTH'(1);
         if (adc_inc > reading_timeout) begin
            pulses.adc_read_due = 1'b1;
            state_nxt.adc_wait  = '0;
         end else begin
            state_nxt.adc_wait = adc_inc;
         end
         state_nxt.millis_in_tenth = tenth_edge ? '0 :
                                     state_cur.millis_in_tenth + MILLI_W'(1);
      end

      // The load comes first, so a value loaded on a tenth boundary steps down at once.
      state_nxt.debounce_left = debounce_loaded;
      if (tenth_edge) begin
         state_nxt.tenths_total = state_cur.tenths_total + COUNT_WIDTH'(1);
         if (debounce_loaded != 8'd0) begin
            state_nxt.debounce_left = debounce_loaded - 8'd1;
         end
         state_nxt.tenths_in_second = second_edge ? '0 :
                                      state_cur.tenths_in_second + TENTH_W'(1);
      end

      if (second_edge) begin
         state_nxt.seconds_total     = state_cur.seconds_total + COUNT_WIDTH'(1);
         state_nxt.pump_bit          = ~state_cur.pump_bit;
         state_nxt.debug_value       = (state_cur.debug_value != 8'd0) ? 8'd0 : DEBUG_ALL_ONES;
         pulses.send_log             = 1'b1;
         state_nxt.seconds_in_minute = minute_edge ? '0 :
                                       state_cur.seconds_in_minute + SECOND_W'(1);
      end

      if (minute_edge) begin
         state_nxt.minutes_total = state_cur.minutes_total + COUNT_WIDTH'(1);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/crtcp_csr.sv =====
// APB-style register block holding the ADC reading timeout.
// Depends on crtcp_pkg for the register map and reset value.
`default_nettype none

module crtcp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [crtcp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output logic [15:0]                      reading_timeout
);
   import crtcp_pkg::*;

   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        hit;

   assign hit    = (paddr[2] == CSR_IDX_READING_TIMEOUT);
   assign pready = 1'b1;

   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && hit) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= READING_TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign prdata          = hit ? {16'd0, timeout_ff} : 32'd0;
   assign reading_timeout = timeout_ff;

endmodule

`default_nettype wire

// ===== rtl/cascaded_realtime_clock_prescaler_core.sv =====
// Cascaded real-time clock prescaler: tick and overflow words in, status words out.
// The status word for an event is registered and valid in the cycle after it is taken.
// One word per cycle unless the sink stalls; the chain update is one pass of crtcp_step.
// Reset is synchronous and active high; it clears all counters, empties the result
// register and loads the reading timeout with 20 milliseconds.
// Depends on crtcp_pkg, crtcp_req_if, crtcp_rsp_if, crtcp_step and crtcp_csr.
`default_nettype none

module cascaded_realtime_clock_prescaler_core (
   input  logic                             clock,
   input  logic                             reset,
   crtcp_req_if.sink                        req_bus,
   crtcp_rsp_if.source                      rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [crtcp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import crtcp_pkg::*;

   // The chain state always reflects every word accepted so far. The result register
   // holds the status word of the latest accepted event until the sink takes it.
   state_type   state_ff;
   state_type   state_in;
   state_type   state_nxt;
   pulse_type   pulses;
   pulse_type   pulses_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        accept;
   logic [15:0] reading_timeout;

   crtcp_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata),
      .pready          (csr_pready),
      .reading_timeout (reading_timeout)
   );

   crtcp_step u_step (
      .state_cur       (state_ff),
      .action          (req_bus.action),
      .load_valid      (req_bus.debounce_load_valid),
      .load_value      (req_bus.debounce_load_value),
      .reading_timeout (reading_timeout),
      .state_nxt       (state_nxt),
      .pulses          (pulses)
   );

   // A new word is taken whenever the result register is empty or is being drained
   // in this same cycle, so back-to-back events flow at full rate.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in     = accept ? state_nxt : state_ff;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The pulses belong to the word in the result register; the counter fields are
   // read straight from the chain state, which only moves when a new word is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         pulses_ff <= pulses;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.millis_count    = 16'(state_ff.millis_total);
   assign rsp_bus.tenths_count    = 16'(state_ff.tenths_total);
   assign rsp_bus.seconds_count   = 16'(state_ff.seconds_total);
   assign rsp_bus.minutes_count   = 16'(state_ff.minutes_total);
   assign rsp_bus.timer_extension = state_ff.overflow_count;
   assign rsp_bus.adc_read_due    = pulses_ff.adc_read_due;
   assign rsp_bus.send_log        = pulses_ff.send_log;
   assign rsp_bus.fuel_pump_led   = state_ff.pump_bit;
   assign rsp_bus.debug_port      = state_ff.debug_value;
   assign rsp_bus.debounce_count  = state_ff.debounce_left;

endmodule

`default_nettype wire

// ===== verif/crtcp_tb_pkg.sv =====
`timescale 1ns / 100ps
// Word types and the status ledger used by the prescaler testbench.
// Depends on crtcp_pkg for the counter widths, event codes and reset values.

package crtcp_tb_pkg;

   import crtcp_pkg::*;

   localparam int MILLIS_PER_TENTH   = 100;
   localparam int TENTHS_PER_SECOND  = 10;
   localparam int SECONDS_PER_MINUTE = 60;
   localparam int MAX_PRINTED        = 200;

   typedef struct packed {
      logic       action;
      logic       load_valid;
      logic [7:0] load_value;
   } event_word_type;

   typedef struct packed {
      logic [15:0] millis_count;
      logic [15:0] tenths_count;
      logic [15:0] seconds_count;
      logic [15:0] minutes_count;
      logic [15:0] timer_extension;
      logic        adc_read_due;
      logic        send_log;
      logic        fuel_pump_led;
      logic [7:0]  debug_port;
      logic [7:0]  debounce_count;
   } status_word_type;

   // Tracks the prescaler chain and keeps the status words still owed by the block.
   class prescaler_status_ledger;
      bit [15:0]            reading_timeout;
      bit [TICK_W-1:0]      tick_phase;
      bit [COUNT_WIDTH-1:0] millis_total;
      bit [COUNT_WIDTH-1:0] tenths_total;
      bit [COUNT_WIDTH-1:0] seconds_total;
      bit [COUNT_WIDTH-1:0] minutes_total;
      bit [6:0]             millis_in_tenth;
      bit [3:0]             tenths_in_second;
      bit [5:0]             seconds_in_minute;
      bit [15:0]            adc_wait;
      bit [7:0]             debounce_left;
      bit                   pump_bit;
      bit [7:0]             debug_value;
      bit [15:0]            overflow_count;
      status_word_type      pending_status[$];
      int                   mismatches;

      function new();
         reading_timeout = READING_TIMEOUT_RESET;
         mismatches      = 0;
      endfunction

      function int pending();
         return pending_status.size();
      endfunction

      // Every mismatch is counted; printing stops after a while to keep the log short.
      task report_mismatch(input string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] error: %s", $realtime, msg);
         end
      endtask

      // Applies one accepted event word and queues the status word it must produce.
      function void note_event(input event_word_type w);
         status_word_type s;
         s = '0;
         if (w.load_valid) begin
            debounce_left = w.load_value;
         end
         if (w.action == ACTION_OVERFLOW) begin
            overflow_count++;
         end else if (tick_phase != TICK_W'(TICKS_PER_MILLI - 1)) begin
            tick_phase++;
         end else begin
            tick_phase = '0;
            millis_total++;
            adc_wait++;
            if (adc_wait > reading_timeout) begin
               s.adc_read_due = 1'b1;
               adc_wait       = '0;
            end
            millis_in_tenth++;
            if (millis_in_tenth == MILLIS_PER_TENTH) begin
               millis_in_tenth = '0;
               tenths_total++;
               if (debounce_left != 0) begin
                  debounce_left--;
               end
               tenths_in_second++;
               if (tenths_in_second == TENTHS_PER_SECOND) begin
                  tenths_in_second = '0;
                  seconds_total++;
                  pump_bit    = ~pump_bit;
                  debug_value = (debug_value != 0) ? 8'h00 : DEBUG_ALL_ONES;
                  s.send_log  = 1'b1;
                  seconds_in_minute++;
                  if (seconds_in_minute == SECONDS_PER_MINUTE) begin
                     seconds_in_minute = '0;
                     minutes_total++;
                  end
               end
            end
         end
         s.millis_count    = 16'(millis_total);
         s.tenths_count    = 16'(tenths_total);
         s.seconds_count   = 16'(seconds_total);
         s.minutes_count   = 16'(minutes_total);
         s.timer_extension = overflow_count;
         s.fuel_pump_led   = pump_bit;
         s.debug_port      = debug_value;
         s.debounce_count  = debounce_left;
         pending_status.push_back(s);
      endfunction

      task check_status(input status_word_type got);
         status_word_type e;
         if (pending_status.size() == 0) begin
            report_mismatch("status word arrived with no event outstanding");
            return;
         end
         e = pending_status.pop_front();
         if (got.millis_count != e.millis_count)
            report_mismatch($sformatf("millis_count got %0d, expected %0d",
                                      got.millis_count, e.millis_count));
         if (got.tenths_count != e.tenths_count)
            report_mismatch($sformatf("tenths_count got %0d, expected %0d",
                                      got.tenths_count, e.tenths_count));
         if (got.seconds_count != e.seconds_count)
            report_mismatch($sformatf("seconds_count got %0d, expected %0d",
                                      got.seconds_count, e.seconds_count));
         if (got.minutes_count != e.minutes_count)
            report_mismatch($sformatf("minutes_count got %0d, expected %0d",
                                      got.minutes_count, e.minutes_count));
         if (got.timer_extension != e.timer_extension)
            report_mismatch($sformatf("timer_extension got %0d, expected %0d",
                                      got.timer_extension, e.timer_extension));
         if (got.adc_read_due != e.adc_read_due)
            report_mismatch($sformatf("adc_read_due got %0b, expected %0b",
                                      got.adc_read_due, e.adc_read_due));
         if (got.send_log != e.send_log)
            report_mismatch($sformatf("send_log got %0b, expected %0b",
                                      got.send_log, e.send_log));
         if (got.fuel_pump_led != e.fuel_pump_led)
            report_mismatch($sformatf("fuel_pump_led got %0b, expected %0b",
                                      got.fuel_pump_led, e.fuel_pump_led));
         if (got.debug_port != e.debug_port)
            report_mismatch($sformatf("debug_port got 0x%0h, expected 0x%0h",
                                      got.debug_port, e.debug_port));
         if (got.debounce_count != e.debounce_count)
            report_mismatch($sformatf("debounce_count got %0d, expected %0d",
                                      got.debounce_count, e.debounce_count));
      endtask
   endclass

endpackage

// ===== verif/cascaded_realtime_clock_prescaler_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cascaded real-time clock prescaler core.
// Depends on crtcp_pkg, crtcp_tb_pkg, the two channel interfaces and the core itself.

module cascaded_realtime_clock_prescaler_core_tb;

   import crtcp_pkg::*;
   import crtcp_tb_pkg::*;

   localparam int   RANDOM_WORDS_PER_PHASE = 330;
   localparam int   LONG_HOLD_CYCLES       = 300;
   // A short closing run of ticks while the timeout sits at its maximum.
   localparam int   SUSTAINED_TICKS        = 64;
   localparam int   DRAIN_CYCLES           = 8;
   localparam int   CYCLE_LIMIT            = 40000;
   // The register map decodes one more word index than it implements.
   localparam logic UNUSED_REG_IDX         = 1'b1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   crtcp_req_if req_chan ();
   crtcp_rsp_if rsp_chan ();

   prescaler_status_ledger ledger = new();

   // Idling controls, set by the stimulus process for each phase.
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          long_hold_req  = 1'b0;
   int          hold_left      = 0;
   int unsigned cycle_count    = 0;

   cascaded_realtime_clock_prescaler_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_chan),
      .rsp_bus     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side. Signals are read right after the edge, so they hold the values the
   // block saw at that edge. A status word is taken whenever valid and ready were both
   // high. The ready line is then chosen for the next edge: a long hold-off when one
   // is requested, otherwise a random stall at the current rate.
   always @(posedge clock) begin : result_side
      status_word_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.millis_count    = rsp_chan.millis_count;
         got.tenths_count    = rsp_chan.tenths_count;
         got.seconds_count   = rsp_chan.seconds_count;
         got.minutes_count   = rsp_chan.minutes_count;
         got.timer_extension = rsp_chan.timer_extension;
         got.adc_read_due    = rsp_chan.adc_read_due;
         got.send_log        = rsp_chan.send_log;
         got.fuel_pump_led   = rsp_chan.fuel_pump_led;
         got.debug_port      = rsp_chan.debug_port;
         got.debounce_count  = rsp_chan.debounce_count;
         ledger.check_status(got);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = LONG_HOLD_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input logic idx);
      return CSR_ADDR_W'({idx, 2'b00});
   endfunction

   function automatic event_word_type make_event(input logic action, input logic load_valid,
                                                 input logic [7:0] load_value);
      event_word_type w;
      w.action     = action;
      w.load_valid = load_valid;
      w.load_value = load_value;
      return w;
   endfunction

   // Offers one event word, idling first at the current rate, and records it in the
   // ledger once it is taken. Valid stays high when the next word follows at once.
   task automatic send_event(input event_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid               <= 1'b1;
      req_chan.action              <= w.action;
      req_chan.debounce_load_valid <= w.load_valid;
      req_chan.debounce_load_value <= w.load_value;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      ledger.note_event(w);
   endtask

   // Stops offering words and waits until every status word owed has been taken.
   // The block always answers, so once nothing is owed it is idle.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (ledger.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Reads the timeout register and compares it with the value the ledger holds.
   task automatic check_timeout_reg();
      logic [31:0] value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= reg_addr(CSR_IDX_READING_TIMEOUT);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (value != {16'h0000, ledger.reading_timeout}) begin
         ledger.report_mismatch($sformatf("reading_timeout reads 0x%0h, expected 0x%0h",
                                          value, ledger.reading_timeout));
      end
   endtask

   // Writes one register, then reads the timeout back. A write to an index that does
   // not exist must leave the timeout untouched.
   task automatic csr_write(input logic idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= reg_addr(idx);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (idx == CSR_IDX_READING_TIMEOUT) begin
         ledger.reading_timeout = data[15:0];
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      check_timeout_reg();
   endtask

   initial begin
      event_word_type w;
      int             ticks_sent;

      reset                        <= 1'b1;
      req_chan.valid               <= 1'b0;
      req_chan.action              <= ACTION_TICK;
      req_chan.debounce_load_valid <= 1'b0;
      req_chan.debounce_load_value <= 8'h00;
      csr_psel                     <= 1'b0;
      csr_penable                  <= 1'b0;
      csr_pwrite                   <= 1'b0;
      csr_paddr                    <= '0;
      csr_pwdata                   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The timeout must come out of reset at its default, and a write to the
      // unimplemented index must not disturb it.
      check_timeout_reg();
      csr_write(UNUSED_REG_IDX, 32'hFFFF_BEEF);

      // Directed words at the default timeout, no idling. A debounce load rides on
      // overflow words as well as ticks; the load value is ignored without the flag.
      send_event(make_event(ACTION_OVERFLOW, 1'b1, 8'hFF));
      send_event(make_event(ACTION_OVERFLOW, 1'b1, 8'h00));
      send_event(make_event(ACTION_TICK, 1'b0, 8'hFF));
      send_event(make_event(ACTION_TICK, 1'b1, 8'hAA));
      send_event(make_event(ACTION_TICK, 1'b1, 8'h55));
      // Thirteen more ticks carry the chain through two millisecond boundaries.
      repeat (13) send_event(make_event(ACTION_TICK, 1'b0, 8'h00));
      send_event(make_event(ACTION_OVERFLOW, 1'b0, 8'h00));
      send_event(make_event(ACTION_OVERFLOW, 1'b1, 8'h01));
      wait_for_drain();

      // A zero timeout forces a reading on every millisecond.
      csr_write(CSR_IDX_READING_TIMEOUT, 32'h0000_0000);

      // Random phases, each with its own idling pattern and timeout setting.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 59;
               recv_stall_pct = 0;
               csr_write(CSR_IDX_READING_TIMEOUT, 32'($urandom_range(1, 40)));
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 59;
               // Junk in the upper half of the bus word must be dropped.
               csr_write(CSR_IDX_READING_TIMEOUT, {16'hA5C3, 16'($urandom)});
            end
            default: begin
               send_idle_pct  = 24;
               recv_stall_pct = 24;
               csr_write(CSR_IDX_READING_TIMEOUT, 32'h0000_0001);
            end
         endcase
         for (int n = 0; n < RANDOM_WORDS_PER_PHASE; n++) begin
            // Mid-phase, the sender once stops until everything owed has come back.
            if (phase == 1 && n == RANDOM_WORDS_PER_PHASE / 2) begin
               wait_for_drain();
            end
            // The result side stops for a long stretch while words keep coming, so
            // the block backs up and has to refuse input.
            if (phase == 2 && n == 100) begin
               long_hold_req = 1'b1;
            end
            // Mostly ticks so that the chain moves; load values lean on the extremes.
            w.action     = ($urandom_range(99) < 12) ? ACTION_OVERFLOW : ACTION_TICK;
            w.load_valid = ($urandom_range(99) < 20);
            case ($urandom_range(7))
               0:       w.load_value = 8'h00;
               1:       w.load_value = 8'hFF;
               default: w.load_value = 8'($urandom);
            endcase
            send_event(w);
         end
         wait_for_drain();
      end

      // Short run at full rate with the timeout at its maximum, so the ADC wait counter
      // only counts up and never forces a reading. Loads now and then ride along.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      csr_write(CSR_IDX_READING_TIMEOUT, 32'h0000_FFFF);
      ticks_sent = 0;
      while (ticks_sent < SUSTAINED_TICKS) begin
         w.action     = ($urandom_range(7) == 0) ? ACTION_OVERFLOW : ACTION_TICK;
         w.load_valid = ($urandom_range(15) == 0);
         w.load_value = 8'($urandom);
         if (w.action == ACTION_TICK) begin
            ticks_sent++;
         end
         send_event(w);
      end
      wait_for_drain();

      if (ledger.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== cascaded_realtime_clock_prescaler_core.f =====
rtl/crtcp_pkg.sv
rtl/crtcp_req_if.sv
rtl/crtcp_rsp_if.sv
rtl/crtcp_step.sv
rtl/crtcp_csr.sv
rtl/cascaded_realtime_clock_prescaler_core.sv
verif/crtcp_tb_pkg.sv
verif/cascaded_realtime_clock_prescaler_core_tb.sv
